// ===== rtl/tis_pkg.sv =====
// Shared constants, types and codes for the trie insert/search core.
package tis_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ALPHABET  = 26;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int USED_W    = NODE_W + 1;
  localparam int LETTER_W  = 5;
  localparam int OP_W      = 2;
  localparam int ROW_W     = ALPHABET * NODE_W;
  localparam int INFO_W    = 2;

  typedef logic [OP_W-1:0] op_t;

  // Operation codes; the unused code behaves as a prefix search.
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_EXACT  = 2'd1;
  localparam op_t OP_PREFIX = 2'd2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  // Per-node bookkeeping: whether the child row was ever written, and the end mark.
  typedef struct packed {
    logic has_kids;
    logic word_end;
  } info_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLR,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/trie_insert_search_core.sv =====
// Top level of the trie insert/search core: item control, walk logic and node stores.
//
// Usage. Words enter one letter per item on the in_ channel; in_tlast marks the final
// item of a word, and only that item produces a result item on the out_ channel.
// The operation field selects insert, exact-word search or prefix search; an item
// whose has_letter bit is clear carries no letter, so a lone last item of that kind
// ends the empty word.
// Item flow. A non-last item is accepted while the child row of the cursor node is read,
// and is then walked. A non-last insert that creates a node goes on to initialize the new
// node's bookkeeping. After its walk, a last item either initializes and marks the node
// it just created, or handles the reached node: an insert sets its end mark, a search
// reads it; the result then goes to the output register. The block takes no new item
// until the previous one is through. The node stores have a registered read, which the
// next letter depends on.
// Reset. After rst_n the trie is empty and the block takes items at once: node rows
// are judged valid through a per-node child flag written when the node is created,
// so no clearing pass over the stores is needed.
// Stalls. The result sits in an output register; while the receiver holds out_tready
// low the block keeps working on non-last items and waits only when it must deliver
// a further result.
module trie_insert_search_core
  import tis_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [1:0] operation, [6:2] letter, [7] has_letter
  input  logic       in_tlast,   // last: final item of the word
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] found, [7:1] zero
  output logic       out_tuser   // status: 1 when the node store ran out during an insert
);

  state_t state_r, state_nxt;

  // Walk state.
  node_t               cursor_r, cursor_nxt;
  logic                miss_r, miss_nxt;
  logic                full_r, full_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  info_t               root_info_r, root_info_nxt;

  // Accepted item.
  op_t                 op_r;
  logic [LETTER_W-1:0] letter_r;
  logic                has_r;
  logic                last_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_status_r, out_status_nxt;

  // Store ports.
  logic                row_we;
  row_t                row_wdata;
  logic [ROW_W-1:0]    row_rdata;
  logic                info_we;
  node_t               info_waddr;
  info_t               info_wdata;
  logic [INFO_W-1:0]   info_rdata;

  // Walk decode.
  info_t               cur_info;
  row_t                row_eff;
  node_t               child;
  logic                accept;
  logic                out_free;
  logic                walk_go;
  logic                letter_bad;
  logic                hit;
  logic                store_full;
  logic                alloc;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_tready;

  // The root's bookkeeping lives in flops, so it is valid straight out of reset; every
  // other node's entry is written when the node is created.
  assign cur_info = (cursor_r == '0) ? root_info_r : info_t'(info_rdata);
  assign row_eff  = cur_info.has_kids ? row_t'(row_rdata) : '0;

  assign walk_go    = has_r && !miss_r && !full_r;
  assign letter_bad = (letter_r >= LETTER_W'(ALPHABET));
  assign child      = row_eff[letter_r];
  assign hit        = (child != '0);
  assign store_full = (used_r >= USED_W'(MAX_NODES));
  assign alloc      = walk_go && !letter_bad && !hit && (op_r == OP_INSERT) && !store_full;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (alloc) begin
          state_nxt = ST_CLR;
        end else if (last_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (!last_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, store writes and result.
  always_comb begin
    cursor_nxt     = cursor_r;
    miss_nxt       = miss_r;
    full_nxt       = full_r;
    used_nxt       = used_r;
    root_info_nxt  = root_info_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    row_we         = 1'b0;
    row_wdata      = row_eff;
    row_wdata[letter_r] = used_r[NODE_W-1:0];
    info_we        = 1'b0;
    info_waddr     = cursor_r;
    info_wdata     = cur_info;

    unique case (state_r)
      ST_IDLE: begin
      end
      ST_WALK: begin
        if (walk_go) begin
          priority if (letter_bad) begin
            miss_nxt = 1'b1;
          end else if (hit) begin
            cursor_nxt = child;
          end else if (op_r != OP_INSERT) begin
            miss_nxt = 1'b1;
          end else if (store_full) begin
            full_nxt = 1'b1;
          end else begin
            // New child: link it into the parent's row and flag the row as written.
            cursor_nxt = used_r[NODE_W-1:0];
            used_nxt   = used_r + USED_W'(1);
            row_we     = 1'b1;
            info_wdata = '{has_kids: 1'b1, word_end: cur_info.word_end};
            if (cursor_r == '0) begin
              root_info_nxt = info_wdata;
            end else begin
              info_we = 1'b1;
            end
          end
        end
      end
      ST_CLR: begin
        // Initialize the freshly created node; a last insert item marks it directly.
        if (!last_r || out_free) begin
          info_we    = 1'b1;
          info_wdata = '{has_kids: 1'b0, word_end: last_r};
          if (last_r) begin
            out_valid_nxt  = 1'b1;
            out_found_nxt  = 1'b1;
            out_status_nxt = 1'b0;
            cursor_nxt     = '0;
            miss_nxt       = 1'b0;
            full_nxt       = 1'b0;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = 1'b0;
          out_status_nxt = 1'b0;
          if (op_r == OP_INSERT) begin
            if (full_r) begin
              out_status_nxt = 1'b1;
            end else if (!miss_r) begin
              out_found_nxt = 1'b1;
              info_wdata    = '{has_kids: cur_info.has_kids, word_end: 1'b1};
              if (cursor_r == '0) begin
                root_info_nxt = info_wdata;
              end else begin
                info_we = 1'b1;
              end
            end
          end else if (!miss_r && !full_r) begin
            out_found_nxt = (op_r == OP_EXACT) ? cur_info.word_end : 1'b1;
          end
          cursor_nxt = '0;
          miss_nxt   = 1'b0;
          full_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      miss_r      <= 1'b0;
      full_r      <= 1'b0;
      used_r      <= USED_W'(1);
      root_info_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      miss_r      <= miss_nxt;
      full_r      <= full_nxt;
      used_r      <= used_nxt;
      root_info_r <= root_info_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    if (accept) begin
      op_r     <= in_tdata[1:0];
      letter_r <= in_tdata[6:2];
      has_r    <= in_tdata[7];
      last_r   <= in_tlast;
    end
  end

  // Child rows: one row of child indices per node, read at the cursor of the next cycle.
  tis_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH(ROW_W)
  ) u_child_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (cursor_r),
    .wdata (row_wdata),
    .raddr (cursor_nxt),
    .rdata (row_rdata)
  );

  // Node bookkeeping: child-row flag and end-of-word mark.
  tis_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH(INFO_W)
  ) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .raddr (cursor_nxt),
    .rdata (info_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_found_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/tis_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module tis_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for trie_insert_search_core: directed table, random words, scoreboard.
module tb_top
  import tis_pkg::*;
();

  // The spare operation code behaves as a prefix search.
  localparam op_t OP_SPARE = 2'd3;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEM_GOAL    = 1450;
  localparam int WORD_MAX     = 16;
  localparam int BOOK_CAP     = 256;

  typedef logic [LETTER_W-1:0] letter_t;

  localparam letter_t L_A   = 5'd0;
  localparam letter_t L_B   = 5'd1;
  localparam letter_t L_Q   = 5'd16;
  localparam letter_t L_R   = 5'd17;
  localparam letter_t L_Y   = 5'd24;
  localparam letter_t L_Z   = 5'd25;
  localparam letter_t L_OUT = 5'd26;
  localparam letter_t L_TOP = 5'd31;

  typedef struct packed {
    logic found;
    logic status;
  } verdict_t;

  typedef struct packed {
    logic [4:0]                  len;
    letter_t [WORD_MAX-1:0]      ch;
  } word_t;

  typedef struct packed {
    op_t     op;
    letter_t ch;
    logic    has;
    logic    last;
    logic    typed;
    logic    found;
    logic    status;
  } plan_row_t;

  // Directed words. Rows with typed set carry a result that is obvious from the
  // trie contents; the others are checked against the software trie.
  localparam int PLAN_LEN = 24;
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    // Empty trie: the empty word is not stored, but the empty prefix exists; then "a" is inserted and found.
    '{OP_EXACT,  L_A,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{OP_PREFIX, L_A,   1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{OP_INSERT, L_A,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{OP_EXACT,  L_A,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    // Highest letters: insert "zy", then search its prefix both ways.
    '{OP_INSERT, L_Z,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_INSERT, L_Y,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{OP_PREFIX, L_Z,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{OP_EXACT,  L_Z,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{OP_SPARE,  L_Z,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_SPARE,  L_Y,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    // Letters outside the alphabet miss, for an insert as well.
    '{OP_INSERT, L_TOP, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{OP_EXACT,  L_OUT, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    // Mixed operations: the insert of q allocates, the exact search of r misses.
    '{OP_INSERT, L_Q,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_EXACT,  L_R,   1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{OP_EXACT,  L_Q,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{OP_PREFIX, L_Q,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    // Items without a letter inside and at the end of a word.
    '{OP_INSERT, L_B,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_INSERT, L_A,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_INSERT, L_A,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    // Inserting the empty word marks the root.
    '{OP_INSERT, L_A,   1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{OP_EXACT,  L_A,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{OP_INSERT, L_Z,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{OP_EXACT,  L_Y,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
    '{OP_PREFIX, L_TOP, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tuser;

  trie_insert_search_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Software copy of the trie.
  node_t    kid_index [MAX_NODES*ALPHABET];
  logic     word_end  [MAX_NODES];
  int       node_count;
  node_t    at_node;
  logic     lost;
  logic     no_room;

  verdict_t pending_verdicts [$];
  verdict_t owed;
  word_t    book [$];
  int       items_sent  = 0;
  int       mismatches  = 0;
  int       hold_asked  = 0;
  int       hold_served = 0;
  logic     calm        = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void trie_clear();
    foreach (kid_index[i]) kid_index[i] = '0;
    foreach (word_end[i]) word_end[i] = 1'b0;
    node_count = 1;
    at_node    = '0;
    lost       = 1'b0;
    no_room    = 1'b0;
  endfunction

  // Advances the software trie by one item; made tells whether a result is due.
  function automatic void trie_apply(input op_t op_raw, input letter_t ch, input logic has,
                                     input logic last, output logic made,
                                     output verdict_t v);
    op_t   op;
    int    slot;
    node_t nxt;
    op   = (op_raw == OP_SPARE) ? OP_PREFIX : op_raw;
    made = last;
    v    = '0;
    if (has && !lost && !no_room) begin
      if (ch >= ALPHABET) begin
        lost = 1'b1;
      end else begin
        slot = int'(at_node) * ALPHABET + int'(ch);
        nxt  = kid_index[slot];
        if (nxt != '0) begin
          at_node = nxt;
        end else if (op != OP_INSERT) begin
          lost = 1'b1;
        end else if (node_count >= MAX_NODES) begin
          no_room = 1'b1;
        end else begin
          kid_index[slot] = node_t'(node_count);
          at_node         = node_t'(node_count);
          node_count++;
        end
      end
    end
    if (last) begin
      if (op == OP_INSERT) begin
        if (no_room) begin
          v.status = 1'b1;
        end else if (!lost) begin
          word_end[at_node] = 1'b1;
          v.found           = 1'b1;
        end
      end else if (!lost && !no_room) begin
        v.found = (op == OP_EXACT) ? word_end[at_node] : 1'b1;
      end
      at_node = '0;
      lost    = 1'b0;
      no_room = 1'b0;
    end
  endfunction

  task automatic note_mismatch(input string what, input logic got, input logic want);
    $display("mismatch at %0t: %s, got %b, want %b", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one item and waits for it to be taken; a typed result overrides the trie's.
  task automatic send_item(input op_t op, input letter_t ch, input logic has, input logic last,
                           input logic typed, input verdict_t typed_v);
    logic     made;
    verdict_t v;
    while (!calm && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {has, ch, op};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    trie_apply(op, ch, has, last, made, v);
    if (made) pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  task automatic go_quiet();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle_all();
    go_quiet();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(input op_t op, input word_t w);
    if (w.len == 0) begin
      send_item(op, letter_t'($urandom_range(31)), 1'b0, 1'b1, 1'b0, '0);
    end else begin
      for (int i = 0; i < w.len; i++)
        send_item(op, w.ch[i], 1'b1, i == w.len - 1, 1'b0, '0);
    end
  endtask

  function automatic word_t fresh_word(input int shortest, input int longest, input int span);
    word_t w;
    w     = '0;
    w.len = 5'($urandom_range(longest, shortest));
    for (int i = 0; i < w.len; i++) w.ch[i] = letter_t'($urandom_range(span - 1));
    return w;
  endfunction

  // A stored word as is, cut short, grown by a letter or with one letter changed.
  function automatic word_t book_variant();
    word_t w;
    if (book.size() == 0) return fresh_word(1, 5, 4);
    w = book[$urandom_range(book.size() - 1)];
    case ($urandom_range(3))
      1: w.len = 5'($urandom_range(w.len));
      2: begin
        if (w.len < WORD_MAX) begin
          w.ch[w.len] = letter_t'($urandom_range(ALPHABET - 1));
          w.len++;
        end
      end
      3: w.ch[$urandom_range(w.len - 1)] = letter_t'($urandom_range(ALPHABET - 1));
      default: ;
    endcase
    return w;
  endfunction

  function automatic void file_word(input word_t w);
    if (book.size() < BOOK_CAP) book.push_back(w);
    else book[$urandom_range(BOOK_CAP - 1)] = w;
  endfunction

  // Random operations, letters and letter flags per item, including out-of-range letters.
  task automatic noise_word();
    int n;
    n = $urandom_range(5, 1);
    for (int i = 0; i < n; i++)
      send_item(op_t'($urandom_range(3)), letter_t'($urandom_range(31)),
                1'($urandom_range(1)), i == n - 1, 1'b0, '0);
  endtask

  task automatic mixed_word();
    word_t w;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      w = fresh_word(1, 6, $urandom_range(1) ? 4 : ALPHABET);
      send_word(OP_INSERT, w);
      file_word(w);
    end else if (pick < 48) begin
      send_word(OP_INSERT, book_variant());
    end else if (pick < 64) begin
      send_word(OP_EXACT, book_variant());
    end else if (pick < 80) begin
      send_word($urandom_range(1) ? OP_PREFIX : OP_SPARE, book_variant());
    end else if (pick < 87) begin
      send_word($urandom_range(1) ? OP_EXACT : OP_PREFIX, fresh_word(1, 5, 4));
    end else if (pick < 90) begin
      send_word(op_t'($urandom_range(3)), '0);
    end else begin
      noise_word();
    end
  endtask

  // Long inserts that allocate nearly every letter, with some searches mixed in.
  task automatic fill_word();
    word_t w;
    if ($urandom_range(9) == 0) begin
      send_word(OP_EXACT, book_variant());
    end else begin
      w = fresh_word(8, 12, ALPHABET);
      send_word(OP_INSERT, w);
      file_word(w);
    end
  endtask

  // Receiver: random back-pressure, calm stretches, and long hold-offs on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // Scoreboard: each delivered result is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch("result with nothing expected", out_tdata[0], 1'bx);
      end else begin
        owed = pending_verdicts.pop_front();
        if (out_tdata[0] !== owed.found) note_mismatch("found", out_tdata[0], owed.found);
        if (out_tuser !== owed.status) note_mismatch("status", out_tuser, owed.status);
      end
    end
  end

  initial begin
    int phase_start;
    int phase_stop;
    trie_clear();
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++)
      send_item(PLAN[i].op, PLAN[i].ch, PLAN[i].has, PLAN[i].last, PLAN[i].typed,
                {PLAN[i].found, PLAN[i].status});
    settle_all();

    // Mixed traffic on a small trie, with a calm stretch and one long receiver hold-off.
    phase_stop = items_sent + 300;
    while (items_sent < phase_stop) begin
      calm = (items_sent >= phase_stop - 200) && (items_sent < phase_stop - 80);
      if (hold_asked == 0 && items_sent >= phase_stop - 60) hold_asked++;
      mixed_word();
    end
    calm = 1'b0;
    settle_all();

    // Use up the node store, then run inserts into the full store.
    while (node_count < MAX_NODES) fill_word();
    for (int i = 0; i < 8; i++) begin
      send_word(OP_INSERT, fresh_word(3, 8, ALPHABET));
      send_word(OP_PREFIX, book_variant());
    end
    settle_all();

    // Mixed traffic on the full trie, with a second hold-off.
    phase_start = items_sent;
    phase_stop  = (items_sent + 120 > ITEM_GOAL) ? items_sent + 120 : ITEM_GOAL;
    while (items_sent < phase_stop) begin
      if (hold_asked == 1 && items_sent >= phase_start + 40) hold_asked++;
      mixed_word();
    end

    go_quiet();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== trie_insert_search_core.f =====
rtl/tis_pkg.sv
rtl/tis_ram.sv
rtl/trie_insert_search_core.sv
sim/tb_top.sv
